// File: src/chm_pkg.sv
// Package for the chained hash map: sizes, codes, payload structs, state enum.
// Used by chained_hash_map and the testbench.
package chm_pkg;

  localparam int NumBuckets = 64;
  localparam int PoolSize   = 256;
  localparam int BktW       = $clog2(NumBuckets);
  localparam int NodeW      = $clog2(PoolSize);
  localparam int LinkW      = NodeW + 1;
  localparam int CntW       = 7;
  localparam logic [LinkW-1:0] Nil = LinkW'(PoolSize);

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqLookup = 2'd1;
  localparam logic [1:0] ReqDelete = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_HRD, S_HEAD, S_ALLOC, S_FRD, S_WRITE,
    S_RD, S_CMP, S_UNLINK, S_FREE, S_DONE
  } state_t;

endpackage

// File: src/chm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module chm_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: src/chained_hash_map.sv
// Chained hash map top level. One item at a time: in_ready is low from acceptance until
// the result has been taken. After acceptance the key hash is reduced by shift-subtract
// modulo (one hash bit per cycle) and the bucket head is read; an insert then takes a
// freed node or a fresh one (or reports full) and links it in at the chain head, while
// lookup and delete walk the chain node by node and finish. Synchronous active-high
// reset marks every bucket empty (valid bits), empties the free list and pool count and
// sets bucket_count to 64; node RAMs are not cleared.
module chained_hash_map (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chm_pkg::req_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chm_pkg::rsp_t        out_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data
);
  import chm_pkg::*;

  state_t state, state_next;
  req_t   req;
  rsp_t   rsp;
  logic   rsp_valid;
  logic [CntW-1:0] bucket_count;
  logic [CntW-1:0] div;

  // bucket valid bits, free list and fresh-node count
  logic [NumBuckets-1:0] head_ok;
  logic [LinkW-1:0] free_head;
  logic [LinkW-1:0] fresh_count;

  // modulo unit state
  logic [31:0]     hsh;
  logic [4:0]      bit_cnt;
  logic [BktW-1:0] rem;
  logic [BktW:0]   rem_sh;
  logic [BktW+1:0] trial;

  // walk registers
  logic [LinkW-1:0] cur, prev, nd, cur_link;
  logic [NodeW:0]   steps;

  // RAM ports
  logic             node_we;
  logic [NodeW-1:0] node_addr;
  logic             link_we;
  logic [NodeW-1:0] link_addr;
  logic [LinkW-1:0] link_wdata;
  logic             head_we;
  logic [LinkW-1:0] head_wdata;
  logic [31:0]      key_rdata, val_rdata;
  logic [LinkW-1:0] link_rdata, head_rdata, head_cur;

  chm_ram #(.Width(32), .Depth(PoolSize)) u_key (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(req.key), .rdata(key_rdata)
  );
  chm_ram #(.Width(32), .Depth(PoolSize)) u_val (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(req.value), .rdata(val_rdata)
  );
  chm_ram #(.Width(LinkW), .Depth(PoolSize)) u_link (
    .clk(clk), .we(link_we), .addr(link_addr), .wdata(link_wdata), .rdata(link_rdata)
  );
  chm_ram #(.Width(LinkW), .Depth(NumBuckets)) u_head (
    .clk(clk), .we(head_we), .addr(rem), .wdata(head_wdata), .rdata(head_rdata)
  );

  assign in_ready  = (state == S_IDLE) && !rsp_valid;
  assign out_valid = rsp_valid;
  assign out_data  = rsp;

  // an unwritten bucket reads as empty
  assign head_cur = head_ok[rem] ? head_rdata : Nil;

  // shift-subtract remainder step
  assign rem_sh = {rem, hsh[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, div};

  always_comb begin
    state_next = state;
    node_we    = 1'b0;
    node_addr  = cur[NodeW-1:0];
    link_we    = 1'b0;
    link_addr  = cur[NodeW-1:0];
    link_wdata = cur;
    head_we    = 1'b0;
    head_wdata = nd;
    unique case (state)
      S_IDLE:   if (in_valid && in_ready) state_next = S_MOD;
      S_MOD:    if (bit_cnt == 5'd0) state_next = S_HRD;
      S_HRD:    state_next = S_HEAD;
      S_HEAD: begin
        unique case (req.req_type)
          ReqInsert: state_next = S_ALLOC;
          ReqLookup, ReqDelete: state_next = S_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_ALLOC: begin
        link_addr = free_head[NodeW-1:0];
        if (free_head < Nil) state_next = S_FRD;
        else if (fresh_count < Nil) state_next = S_WRITE;
        else state_next = S_DONE;
      end
      S_FRD:    state_next = S_WRITE;
      S_WRITE: begin
        // new node goes in at the head of its chain
        node_we    = 1'b1;
        node_addr  = nd[NodeW-1:0];
        link_we    = 1'b1;
        link_addr  = nd[NodeW-1:0];
        link_wdata = cur;
        head_we    = 1'b1;
        head_wdata = nd;
        state_next = S_DONE;
      end
      S_RD: begin
        if (cur < Nil && steps < (NodeW+1)'(PoolSize)) state_next = S_CMP;
        else state_next = S_DONE;
      end
      S_CMP: begin
        if (key_rdata == req.key) begin
          if (req.req_type == ReqLookup) state_next = S_DONE;
          else if (prev < Nil) state_next = S_UNLINK;
          else begin
            // first node of the chain: head takes its successor
            head_we    = 1'b1;
            head_wdata = link_rdata;
            state_next = S_FREE;
          end
        end else state_next = S_RD;
      end
      S_UNLINK: begin
        link_we    = 1'b1;
        link_addr  = prev[NodeW-1:0];
        link_wdata = cur_link;
        state_next = S_FREE;
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_addr  = cur[NodeW-1:0];
        link_wdata = free_head;
        state_next = S_DONE;
      end
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      bucket_count <= CntW'(NumBuckets);
      head_ok      <= '0;
      free_head    <= Nil;
      fresh_count  <= '0;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      if (out_valid && out_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          req     <= in_data;
          hsh     <= in_data.key_hash;
          rem     <= '0;
          bit_cnt <= 5'd31;
          if (bucket_count == '0) div <= CntW'(1);
          else if (bucket_count > CntW'(NumBuckets)) div <= CntW'(NumBuckets);
          else div <= bucket_count;
          rsp <= '{status: StMiss, found: 1'b0, value_out: 32'd0};
        end
        S_MOD: begin
          hsh <= {hsh[30:0], 1'b0};
          if (!trial[BktW+1]) rem <= trial[BktW-1:0];
          else rem <= rem_sh[BktW-1:0];
          bit_cnt <= bit_cnt - 5'd1;
        end
        S_HEAD: begin
          cur   <= head_cur;
          prev  <= Nil;
          steps <= '0;
        end
        S_ALLOC: begin
          if (free_head < Nil) nd <= free_head;
          else if (fresh_count < Nil) begin
            nd <= fresh_count;
            fresh_count <= fresh_count + LinkW'(1);
          end else rsp.status <= StFull;
        end
        S_FRD: free_head <= link_rdata;
        S_WRITE: begin
          head_ok[rem] <= 1'b1;
          rsp.status   <= StOk;
        end
        S_CMP: begin
          if (key_rdata == req.key) begin
            rsp.status <= StOk;
            rsp.found  <= 1'b1;
            cur_link   <= link_rdata;
            if (req.req_type == ReqLookup) rsp.value_out <= val_rdata;
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + (NodeW+1)'(1);
          end
        end
        S_FREE: free_head <= cur;
        S_DONE: rsp_valid <= 1'b1;
        S_HRD, S_RD, S_UNLINK: ;
        default: ;
      endcase
    end
  end
endmodule

// File: dv/tb.sv
// Self-checking testbench for chained_hash_map: directed, pool-full,
// configuration and random phases, checked against an internal map model.
// Depends on chm_pkg and the chained_hash_map RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  rsp_t  out_data;
  logic  cfg_we;
  logic [6:0] cfg_data;

  chained_hash_map dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Map model state
  logic [LinkW-1:0] mdl_head [NumBuckets];
  logic [31:0]      mdl_key [PoolSize];
  logic [31:0]      mdl_val [PoolSize];
  logic [LinkW-1:0] mdl_link [PoolSize];
  logic [LinkW-1:0] mdl_free;
  int unsigned      mdl_fresh;
  logic [6:0]       mdl_buckets;
  int               mdl_live;

  rsp_t  rsp_q[$];
  int    errors;
  int    n_sent, n_checked, n_full, n_hits, n_del;
  logic [31:0] key_set[$];

  // Receiver hold-off requests
  int  hold_len;
  bit  hold_go, hold_seen;
  int  hold_cnt;
  bit  quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("chained_hash_map regression: fail");
    $finish;
  end

  function automatic int unsigned eff_buckets();
    if (mdl_buckets == 0) return 1;
    if (mdl_buckets > NumBuckets) return NumBuckets;
    return mdl_buckets;
  endfunction

  // Predict one request and update the map model
  function automatic rsp_t map_apply(req_t r);
    rsp_t o;
    int unsigned b, steps;
    logic [LinkW-1:0] cur, prev, nd;
    o = '0;
    o.status = StMiss;
    if (r.req_type == ReqUnused) return o;
    b = r.key_hash % eff_buckets();
    if (r.req_type == ReqInsert) begin
      if (mdl_free != Nil) begin
        nd = mdl_free;
        mdl_free = mdl_link[nd];
      end else if (mdl_fresh < PoolSize) begin
        nd = LinkW'(mdl_fresh);
        mdl_fresh++;
      end else begin
        o.status = StFull;
        n_full++;
        return o;
      end
      mdl_key[nd] = r.key;
      mdl_val[nd] = r.value;
      mdl_link[nd] = mdl_head[b];
      mdl_head[b] = nd;
      mdl_live++;
      o.status = StOk;
      return o;
    end
    prev = Nil;
    cur = mdl_head[b];
    for (steps = 0; steps < PoolSize && cur < PoolSize; steps++) begin
      if (mdl_key[cur] == r.key) begin
        o.status = StOk;
        o.found = 1'b1;
        if (r.req_type == ReqLookup) begin
          o.value_out = mdl_val[cur];
          n_hits++;
        end else begin
          if (prev != Nil) mdl_link[prev] = mdl_link[cur];
          else mdl_head[b] = mdl_link[cur];
          mdl_link[cur] = mdl_free;
          mdl_free = cur;
          mdl_live--;
          n_del++;
        end
        return o;
      end
      prev = cur;
      cur = mdl_link[cur];
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    rsp_t w;
    int r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (rsp_q.size() == 0) begin
          report("unexpected result", out_data.value_out, 32'h0);
        end else begin
          w = rsp_q.pop_front();
          if (out_data.status !== w.status)
            report("status", 32'(out_data.status), 32'(w.status));
          if (out_data.found !== w.found)
            report("found", 32'(out_data.found), 32'(w.found));
          if (out_data.value_out !== w.value_out)
            report("value_out", out_data.value_out, w.value_out);
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        out_ready <= (r >= 30) || (r < 2 && hold_cnt == 0 && ($urandom_range(0, 1) == 1));
        if (r == 5) hold_cnt = $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] hash_of(logic [31:0] k);
    return (k * 32'h9E3779B1) ^ (k >> 13);
  endfunction

  // Offer one item, wait for acceptance, then an optional gap
  task automatic send(logic [1:0] kind, logic [31:0] k, logic [31:0] h, logic [31:0] v);
    req_t r;
    int g;
    r.req_type = kind;
    r.key = k;
    r.key_hash = h;
    r.value = v;
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_q.push_back(map_apply(r));
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_key(logic [1:0] kind, logic [31:0] k);
    send(kind, k, hash_of(k), $urandom());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_buckets(logic [6:0] n);
    drain();
    cfg_data <= n;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_buckets = n;
    @(posedge clk);
  endtask

  // Field extremes, every request kind, duplicates and misses
  task automatic test_directed();
    send(ReqInsert, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send(ReqInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send(ReqLookup, 32'h0, 32'h0, 32'h0);
    send(ReqLookup, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ReqLookup, 32'h1234_5678, 32'h0, 32'h0);
    send(ReqInsert, 32'h55, 32'h3F, 32'hA5A5_A5A5);
    send(ReqInsert, 32'h55, 32'h3F, 32'h5A5A_5A5A);
    send(ReqLookup, 32'h55, 32'h3F, 32'h0);
    send(ReqDelete, 32'h55, 32'h3F, 32'h0);
    send(ReqLookup, 32'h55, 32'h3F, 32'h0);
    send(ReqDelete, 32'h55, 32'h3F, 32'h0);
    send(ReqDelete, 32'h55, 32'h3F, 32'h0);
    send(ReqUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ReqUnused, 32'h0, 32'h0, 32'h0);
    send(ReqInsert, 32'hAAAA_AAAA, 32'h8000_0000, 32'h5555_5555);
    send(ReqLookup, 32'hAAAA_AAAA, 32'h8000_0000, 32'h0);
    send(ReqDelete, 32'h0, 32'h0, 32'h0);
    send(ReqLookup, 32'h0, 32'h0, 32'h0);
  endtask

  // Fill the pool past capacity, then free every node through deletes
  task automatic test_pool_full();
    logic [31:0] k;
    logic [31:0] added[$];
    set_buckets(7'd64);
    while (mdl_live < PoolSize) begin
      k = $urandom();
      added.push_back(k);
      send_key(ReqInsert, k);
    end
    repeat (6) send_key(ReqInsert, $urandom());
    foreach (added[i]) if (i % 9 == 0) send_key(ReqLookup, added[i]);
    drain();
    added.shuffle();
    foreach (added[i]) send_key(ReqDelete, added[i]);
    repeat (4) send_key(ReqInsert, $urandom());
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    drain();
    hold_len = 400;
    hold_go = ~hold_go;
    quiet = 1'b1;
    repeat (12) send_key(ReqInsert, key_set[$urandom_range(0, key_set.size() - 1)]);
    quiet = 1'b0;
    drain();
  endtask

  task automatic random_ops(int count);
    int r;
    logic [31:0] k;
    repeat (count) begin
      r = $urandom_range(0, 99);
      k = key_set[$urandom_range(0, key_set.size() - 1)];
      if (r < 3) send(ReqUnused, $urandom(), $urandom(), $urandom());
      else if (r < 8) send(2'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom());
      else if (r < 40 && mdl_live < 200) send_key(ReqInsert, k);
      else if (r < 72) send_key(ReqLookup, k);
      else send_key(ReqDelete, k);
    end
  endtask

  // Bucket count extremes, including zero and above the table size
  task automatic test_bucket_counts();
    set_buckets(7'd1);
    random_ops(40);
    set_buckets(7'd0);
    random_ops(30);
    set_buckets(7'd127);
    random_ops(60);
    set_buckets(7'd65);
    random_ops(30);
    set_buckets(7'd13);
    random_ops(60);
  endtask

  task automatic test_random();
    set_buckets(7'd64);
    random_ops(120);
    set_buckets(7'($urandom_range(2, 63)));
    random_ops(150);
    set_buckets(7'd64);
    random_ops(100);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    n_sent = 0; n_checked = 0; n_full = 0; n_hits = 0; n_del = 0;
    hold_len = 0; hold_go = 1'b0; hold_seen = 1'b0; hold_cnt = 0; quiet = 1'b0;
    foreach (mdl_head[i]) mdl_head[i] = Nil;
    foreach (mdl_key[i]) begin
      mdl_key[i] = '0; mdl_val[i] = '0; mdl_link[i] = '0;
    end
    mdl_free = Nil;
    mdl_fresh = 0;
    mdl_live = 0;
    mdl_buckets = 7'd64;
    key_set.push_back(32'h0);
    key_set.push_back(32'hFFFF_FFFF);
    repeat (30) key_set.push_back($urandom());
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_backpressure();
    test_bucket_counts();
    test_random();

    drain();
    repeat (50) @(posedge clk);
    if (rsp_q.size() != 0) report("results outstanding", 32'(rsp_q.size()), 32'h0);
    $display("Covered %0d requests: %0d lookup hits, %0d deletes, %0d pool-full drops,",
             n_sent, n_hits, n_del, n_full);
    $display("bucket counts 0, 1, 13, 64, 65 and 127, plus a long receiver stall.");
    if (errors == 0) begin
      $display("chained_hash_map regression: pass");
    end else begin
      $display("chained_hash_map regression: fail");
    end
    $finish;
  end
endmodule

// File: files.f
src/chm_pkg.sv
src/chm_ram.sv
src/chained_hash_map.sv
dv/tb.sv
